>>> src/swrt_pkg.sv
// Shared types and constants for the sliding window receive tracker.
`timescale 1ns / 1ps

package swrt_pkg;

  // Window geometry
  localparam int SLOTS         = 5;
  localparam int PAYLOAD_BYTES = 900;
  localparam int WINDOW_BYTES  = 5120;

  localparam int SEQ_W  = 31;
  localparam int LEN_W  = 10;
  localparam int WIN_W  = 13;
  localparam int SCNT_W = $clog2(SLOTS + 1);

  // Advertised window as carried in the 13-bit field
  localparam logic [WIN_W-1:0] ADV_WINDOW = WIN_W'(WINDOW_BYTES % (1 << WIN_W));

  // Request kinds
  localparam logic [1:0] REQ_DATA = 2'd0;
  localparam logic [1:0] REQ_FIN  = 2'd1;
  localparam logic [1:0] REQ_SYN  = 2'd2;
  localparam logic [1:0] REQ_BAD  = 2'd3;

  // Ack kinds
  localparam logic [1:0] KIND_CONN = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_FIN  = 2'd2;

  // One queued answer; rep marks a second identical ack still to send
  typedef struct packed {
    logic [1:0]       kind;
    logic [SEQ_W-1:0] ack_no;
    logic [WIN_W-1:0] adv;
    logic             released;
    logic             rep;
  } ack_entry_t;

endpackage

>>> src/swrt_window.sv
// Receive window state and the per-header ack decision.
`timescale 1ns / 1ps

module swrt_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [1:0]                    req_type,
  input  logic [swrt_pkg::SEQ_W-1:0]    seq_no,
  input  logic [swrt_pkg::LEN_W-1:0]    data_len,
  output swrt_pkg::ack_entry_t          res
);

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_XFER = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  phase_t                          phase, phase_next;
  logic [swrt_pkg::SLOTS-1:0]      slot_valid, slot_valid_next;
  logic [swrt_pkg::SEQ_W-1:0]      window_base, window_base_next;
  logic [swrt_pkg::SEQ_W-1:0]      cum_ack, cum_ack_next;
  logic [swrt_pkg::SEQ_W-1:0]      final_seq, final_seq_next;

  logic [swrt_pkg::SEQ_W-1:0]      fin_cand;
  logic [swrt_pkg::SEQ_W-1:0]      diff;
  logic                            in_win;
  logic [swrt_pkg::SLOTS-1:0]      hit;
  logic [swrt_pkg::SLOTS-1:0]      merged;
  logic [swrt_pkg::SCNT_W-1:0]     run;
  logic                            run_on;
  logic [31:0]                     ack_sum;
  logic                            capped;
  logic [swrt_pkg::SEQ_W-1:0]      ack_new;
  logic                            rel;

  // Final sequence candidate from a short segment
  always_comb begin
    logic [31:0] s;
    s = {1'b0, seq_no} + {22'd0, data_len};
    fin_cand = s[swrt_pkg::SEQ_W-1:0];
  end

  // Locate the slot this segment falls in
  assign in_win = (seq_no >= cum_ack) && (seq_no >= window_base);
  assign diff   = seq_no - window_base;

  always_comb begin
    for (int i = 0; i < swrt_pkg::SLOTS; i++) begin
      hit[i] = in_win
             && ({1'b0, diff} >= 32'(i) * 32'(swrt_pkg::PAYLOAD_BYTES))
             && ({1'b0, diff} <  32'(i + 1) * 32'(swrt_pkg::PAYLOAD_BYTES));
    end
  end

  // Count the run of filled slots from the window base
  assign merged = slot_valid | hit;

  always_comb begin
    run    = '0;
    run_on = 1'b1;
    for (int i = 0; i < swrt_pkg::SLOTS; i++) begin
      run_on = run_on & merged[i];
      if (run_on) begin
        run = run + swrt_pkg::SCNT_W'(1);
      end
    end
  end

  // Advance the ack over the run, capped at a known final sequence
  always_comb begin
    logic [31:0] fin_use;
    fin_use = (32'(data_len) < 32'(swrt_pkg::PAYLOAD_BYTES)) ? {1'b0, fin_cand}
                                                             : {1'b0, final_seq};
    ack_sum = {1'b0, window_base}
            + 32'(run) * 32'(swrt_pkg::PAYLOAD_BYTES);
    capped  = (run != '0) && (fin_use != '0) && (ack_sum > fin_use);
    ack_new = capped ? fin_use[swrt_pkg::SEQ_W-1:0] : ack_sum[swrt_pkg::SEQ_W-1:0];
    rel     = capped || (32'(run) == 32'(swrt_pkg::SLOTS));
  end

  // Decide the answer and the next state
  always_comb begin
    phase_next       = phase;
    slot_valid_next  = slot_valid;
    window_base_next = window_base;
    cum_ack_next     = cum_ack;
    final_seq_next   = final_seq;
    res.kind         = swrt_pkg::KIND_FIN;
    res.ack_no       = '0;
    res.adv          = '0;
    res.released     = 1'b0;
    res.rep          = 1'b0;
    unique case (phase)
      PH_WAIT: begin
        res.adv = swrt_pkg::ADV_WINDOW;
        if (req_type == swrt_pkg::REQ_BAD) begin
          res.kind   = swrt_pkg::KIND_DATA;
          res.ack_no = cum_ack;
        end else begin
          res.kind         = swrt_pkg::KIND_CONN;
          phase_next       = PH_XFER;
          slot_valid_next  = '0;
          window_base_next = '0;
        end
      end
      PH_XFER: begin
        if (req_type == swrt_pkg::REQ_BAD) begin
          res.kind   = swrt_pkg::KIND_DATA;
          res.ack_no = cum_ack;
          res.adv    = swrt_pkg::ADV_WINDOW;
          res.rep    = 1'b1;
        end else if (req_type == swrt_pkg::REQ_FIN) begin
          phase_next = PH_DONE;
        end else begin
          if (32'(data_len) < 32'(swrt_pkg::PAYLOAD_BYTES)) begin
            final_seq_next = fin_cand;
          end
          res.kind = swrt_pkg::KIND_DATA;
          res.adv  = swrt_pkg::ADV_WINDOW;
          if (hit != '0) begin
            cum_ack_next = ack_new;
            res.ack_no   = ack_new;
            res.released = rel;
            if (rel) begin
              slot_valid_next  = '0;
              window_base_next = ack_new;
            end else begin
              slot_valid_next = merged;
            end
          end else begin
            res.ack_no = cum_ack;
          end
        end
      end
      default: begin
        // done: every header gets one more fin ack
      end
    endcase
  end

  // Hold window state; update on each processed header
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      slot_valid  <= '0;
      window_base <= '0;
      cum_ack     <= swrt_pkg::SEQ_W'(1);
      final_seq   <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      slot_valid  <= slot_valid_next;
      window_base <= window_base_next;
      cum_ack     <= cum_ack_next;
      final_seq   <= final_seq_next;
    end
  end

endmodule

>>> src/sliding_window_receive_tracker_unit.sv
// Top level of the sliding window receive tracker.
// Usage:
//   The request channel (req_valid/req_stall) carries one parsed segment
//   header per transaction: req_type, seq_no and data_len. The ack channel
//   (ack_valid/ack_stall) returns one or two ack transactions per header;
//   last marks the final ack of a header. A bad magic header during
//   transfer yields two identical data acks.
//   An accepted header waits in the input register until the ack queue has
//   room, is then processed into the queue, and its first ack is offered.
//   Throughput: one header per cycle while every header yields one ack and
//   the receiver does not stall; a header with two acks holds the ack channel
//   for both. The two-entry ack queue behind the window logic bounds the rate.
//   Reset (rst, synchronous) empties the input register and ack queue and
//   returns the window to waiting for a connection with ack number one.
//   When the receiver stalls, queued acks hold; once the queue is full the
//   header in the input register waits and req_stall rises.
//   req_stall depends only on registered state, never on ack_stall.
`timescale 1ns / 1ps

module sliding_window_receive_tracker_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    req_type,
  input  logic [swrt_pkg::SEQ_W-1:0]    seq_no,
  input  logic [swrt_pkg::LEN_W-1:0]    data_len,
  output logic                          ack_valid,
  input  logic                          ack_stall,
  output logic [1:0]                    ack_kind,
  output logic [swrt_pkg::SEQ_W-1:0]    ack_no,
  output logic [swrt_pkg::WIN_W-1:0]    adv_window,
  output logic                          released,
  output logic                          last
);

  logic                            in_full;
  logic [1:0]                      in_type;
  logic [swrt_pkg::SEQ_W-1:0]      in_seq;
  logic [swrt_pkg::LEN_W-1:0]      in_len;

  swrt_pkg::ack_entry_t            q [2];
  logic                            wr_ptr;
  logic                            rd_ptr;
  logic [1:0]                      count;

  swrt_pkg::ack_entry_t            res;
  logic                            fire;
  logic                            take;
  logic                            pop;
  swrt_pkg::ack_entry_t            head;

  assign fire      = in_full && (count != 2'd2);
  assign req_stall = in_full && !fire;
  assign take      = req_valid && !req_stall;

  assign head       = q[rd_ptr];
  assign ack_valid  = (count != 2'd0);
  assign ack_kind   = head.kind;
  assign ack_no     = head.ack_no;
  assign adv_window = head.adv;
  assign released   = head.released;
  assign last       = !head.rep;
  assign pop        = ack_valid && !ack_stall;

  swrt_window u_window (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .req_type (in_type),
    .seq_no   (in_seq),
    .data_len (in_len),
    .res      (res)
  );

  // Hold the accepted header until the queue has room
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_type <= req_type;
      in_seq  <= seq_no;
      in_len  <= data_len;
    end
  end

  // Queue acks; drop the repeat mark before retiring a doubled entry
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (fire) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !head.rep) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({fire, pop && !head.rep})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.rep) begin
      q[rd_ptr].rep <= 1'b0;
    end
    if (fire) begin
      q[wr_ptr] <= res;
    end
  end

endmodule

>>> src/swrt_checker.sv
// Port-level checks for the sliding window receive tracker, bound to the top.
`timescale 1ns / 1ps

module swrt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          ack_valid,
  input logic                          ack_stall,
  input logic [1:0]                    ack_kind,
  input logic [swrt_pkg::SEQ_W-1:0]    ack_no,
  input logic [swrt_pkg::WIN_W-1:0]    adv_window,
  input logic                          released,
  input logic                          last
);

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !ack_valid)
    else $error("ack offered right after reset");

  // A stalled ack transaction holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    ack_valid && ack_stall |=> ack_valid && $stable(ack_no) && $stable(ack_kind)
      && $stable(last) && $stable(released))
    else $error("stalled ack transaction changed");

  // Fin acks carry zero number and zero window and end their header
  a_fin_zero: assert property (@(posedge clk) disable iff (rst)
    ack_valid && (ack_kind == swrt_pkg::KIND_FIN) |->
      (ack_no == '0) && (adv_window == '0) && last && !released)
    else $error("fin ack with nonzero fields");

  // Release appears only on a single data ack
  a_release_data: assert property (@(posedge clk) disable iff (rst)
    ack_valid && released |-> (ack_kind == swrt_pkg::KIND_DATA) && last)
    else $error("release flag on wrong ack");

  // A first-of-two ack is followed by its twin
  a_twin: assert property (@(posedge clk) disable iff (rst)
    ack_valid && !ack_stall && !last |=>
      ack_valid && last && (ack_kind == swrt_pkg::KIND_DATA) && $stable(ack_no))
    else $error("doubled ack not repeated");

endmodule

bind sliding_window_receive_tracker_unit swrt_checker u_swrt_checker (.*);

>>> tb/swrt_ack_checker.sv
// Ack predictor and comparator for the sliding window receive tracker.
`timescale 1ns / 1ps

module swrt_ack_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_stall,
  input  logic [1:0]                 req_type,
  input  logic [swrt_pkg::SEQ_W-1:0] seq_no,
  input  logic [swrt_pkg::LEN_W-1:0] data_len,
  input  logic                       ack_valid,
  input  logic                       ack_stall,
  input  logic [1:0]                 ack_kind,
  input  logic [swrt_pkg::SEQ_W-1:0] ack_no,
  input  logic [swrt_pkg::WIN_W-1:0] adv_window,
  input  logic                       released,
  input  logic                       last,
  output int                         fail_count,
  output int                         due_count
);
  import swrt_pkg::*;

  // Receiver phases
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_XFER = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SEQ_W-1:0] ack_no;
    logic [WIN_W-1:0] adv;
    logic             released;
    logic             last;
  } ack_exp_t;

  ack_exp_t         acks_due[$];
  logic [1:0]       phase_q;
  logic [SLOTS-1:0] slot_mark;
  logic [SEQ_W-1:0] base_q;
  logic [SEQ_W-1:0] cum_q;
  logic [SEQ_W-1:0] final_q;
  int               errs = 0;
  int               waiting = 0;

  assign fail_count = errs;
  assign due_count  = waiting;

  task automatic flag_mismatch(input string what);
    if (errs < 40) $display("[%0t] ack mismatch: %s", $realtime, what);
    errs++;
  endtask

  task automatic queue_ack(input logic [1:0] kind, input logic [SEQ_W-1:0] num,
                           input logic [WIN_W-1:0] adv, input logic rel, input logic lst);
    ack_exp_t e;
    e.kind     = kind;
    e.ack_no   = num;
    e.adv      = adv;
    e.released = rel;
    e.last     = lst;
    acks_due.push_back(e);
  endtask

  // Mark the slot of a data segment, advance the cumulative ack and release a full window
  task automatic take_segment(input logic [SEQ_W-1:0] s, input logic [LEN_W-1:0] l,
                              output logic rel);
    longint unsigned span;
    longint unsigned ack;
    bit              full;
    int              i;
    rel = 1'b0;
    // a short segment fixes the end of the stream, wherever it lands
    if (l < PAYLOAD_BYTES) begin
      span    = 64'(s) + 64'(l);
      final_q = span[SEQ_W-1:0];
    end
    if (s < cum_q || s < base_q) return;
    span = (64'(s) - 64'(base_q)) / PAYLOAD_BYTES;
    if (span >= SLOTS) return;
    slot_mark[($clog2(SLOTS))'(span)] = 1'b1;
    // advance over the valid prefix, capped at the final sequence
    ack  = 64'(base_q);
    full = 1'b1;
    for (i = 0; i < SLOTS; i++) begin
      full = full && slot_mark[i];
      if (full) begin
        ack += PAYLOAD_BYTES;
        if (final_q != '0 && ack > 64'(final_q)) begin
          ack = 64'(final_q);
          break;
        end
      end
    end
    cum_q = ack[SEQ_W-1:0];
    if (full) begin
      slot_mark = '0;
      base_q    = cum_q;
      rel       = 1'b1;
    end
  endtask

  // Work out the acks one header causes
  task automatic track_header(input logic [1:0] rt, input logic [SEQ_W-1:0] s,
                              input logic [LEN_W-1:0] l);
    logic rel;
    case (phase_q)
      PH_WAIT: begin
        if (rt == REQ_BAD) begin
          queue_ack(KIND_DATA, cum_q, ADV_WINDOW, 1'b0, 1'b1);
        end else begin
          queue_ack(KIND_CONN, '0, ADV_WINDOW, 1'b0, 1'b1);
          phase_q   = PH_XFER;
          slot_mark = '0;
          base_q    = '0;
        end
      end
      PH_XFER: begin
        if (rt == REQ_BAD) begin
          queue_ack(KIND_DATA, cum_q, ADV_WINDOW, 1'b0, 1'b0);
          queue_ack(KIND_DATA, cum_q, ADV_WINDOW, 1'b0, 1'b1);
        end else if (rt == REQ_FIN) begin
          queue_ack(KIND_FIN, '0, '0, 1'b0, 1'b1);
          phase_q = PH_DONE;
        end else begin
          take_segment(s, l, rel);
          queue_ack(KIND_DATA, cum_q, ADV_WINDOW, rel, 1'b1);
        end
      end
      default: begin
        queue_ack(KIND_FIN, '0, '0, 1'b0, 1'b1);
      end
    endcase
  endtask

  // Compare each ack transaction with the oldest expectation, then predict new headers
  always @(posedge clk) begin : watch
    ack_exp_t want;
    if (rst) begin
      phase_q   = PH_WAIT;
      slot_mark = '0;
      base_q    = '0;
      cum_q     = SEQ_W'(1);
      final_q   = '0;
      acks_due.delete();
    end else begin
      if (ack_valid && !ack_stall) begin
        if (acks_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected ack kind %0d no %0d", ack_kind, ack_no));
        end else begin
          want = acks_due.pop_front();
          if (ack_kind !== want.kind)
            flag_mismatch($sformatf("ack_kind %0d, expected %0d", ack_kind, want.kind));
          if (ack_no !== want.ack_no)
            flag_mismatch($sformatf("ack_no %0d, expected %0d", ack_no, want.ack_no));
          if (adv_window !== want.adv)
            flag_mismatch($sformatf("adv_window %0d, expected %0d", adv_window, want.adv));
          if (released !== want.released)
            flag_mismatch($sformatf("released %0d, expected %0d", released, want.released));
          if (last !== want.last)
            flag_mismatch($sformatf("last %0d, expected %0d", last, want.last));
        end
      end
      if (req_valid && !req_stall) track_header(req_type, seq_no, data_len);
    end
    waiting = acks_due.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top for the sliding window receive tracker: segment stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import swrt_pkg::*;

  localparam int HEADERS     = 1900;
  localparam int QUIET_AFTER = 1700;
  localparam int SPAN        = SLOTS * PAYLOAD_BYTES;
  localparam logic [SEQ_W-1:0] SEQ_TOP  = '1;
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(PAYLOAD_BYTES);

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic [1:0]       req_type  = REQ_DATA;
  logic [SEQ_W-1:0] seq_no    = '0;
  logic [LEN_W-1:0] data_len  = '0;
  logic             ack_stall = 1'b0;
  logic             req_stall;
  logic             ack_valid;
  logic [1:0]       ack_kind;
  logic [SEQ_W-1:0] ack_no;
  logic [WIN_W-1:0] adv_window;
  logic             released;
  logic             last;
  int               fail_count;
  int               due_count;

  int               gap_pct   = 0;
  int               stall_pct = 0;
  int               hdr_count = 0;
  int               idle_mix[4] = '{0, 4, 15, 45};
  logic [SEQ_W-1:0] grid;

  sliding_window_receive_tracker_unit DUT (.*);

  swrt_ack_checker ack_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hold off the ack channel in random bursts
  always begin
    @(negedge clk);
    if (!rst && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      ack_stall <= 1'b1;
      repeat ($urandom_range(1, 19)) @(negedge clk);
      ack_stall <= 1'b0;
    end
  end

  // Offer one header and hold it until the transaction completes
  task automatic put_header(input logic [1:0] rt, input logic [SEQ_W-1:0] s,
                            input logic [LEN_W-1:0] l);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= rt;
    seq_no    <= s;
    data_len  <= l;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    hdr_count++;
    @(negedge clk);
  endtask

  function automatic logic [1:0] data_req();
    return ($urandom_range(0, 9) == 0) ? REQ_SYN : REQ_DATA;
  endfunction

  function automatic logic [1:0] any_req(input bit with_bad);
    case ($urandom_range(0, with_bad ? 3 : 2))
      0:       return REQ_DATA;
      1:       return REQ_FIN;
      2:       return REQ_SYN;
      default: return REQ_BAD;
    endcase
  endfunction

  // Send a header that touches no slot: bad magic, beyond the window or below it
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: put_header(REQ_BAD, SEQ_W'($urandom()), LEN_W'($urandom_range(0, PAYLOAD_BYTES)));
      1: put_header(data_req(), SEQ_W'(grid + SPAN + $urandom_range(0, 1 << 20)),
                    FULL_LEN);
      default: put_header(data_req(), SEQ_W'($urandom_range(0, grid - 1)), FULL_LEN);
    endcase
  endtask

  initial begin : stimulus
    int               top_slot;
    int               k;
    int               w;
    bit               closing;
    logic [SLOTS-1:0] need;
    logic [SLOTS-1:0] filled;
    logic [LEN_W-1:0] short_len;
    logic [LEN_W-1:0] tail_len;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Bad magic while waiting, then any good header opens the connection
    put_header(REQ_BAD, '0, '0);
    put_header(REQ_BAD, SEQ_TOP, FULL_LEN);
    put_header(any_req(1'b0), SEQ_W'($urandom()), LEN_W'($urandom_range(0, PAYLOAD_BYTES)));
    put_header(REQ_BAD, SEQ_W'(12345), LEN_W'(1));
    // below the ack, then one slot past the window
    put_header(REQ_DATA, '0, FULL_LEN);
    put_header(REQ_DATA, SEQ_W'(SPAN + 1), FULL_LEN);
    // fill the first window out of order, SYN counting as data
    put_header(REQ_SYN, SEQ_W'(PAYLOAD_BYTES + 1), FULL_LEN);
    put_header(REQ_DATA, SEQ_W'(1), FULL_LEN);
    put_header(REQ_DATA, SEQ_W'(3 * PAYLOAD_BYTES + 1), FULL_LEN);
    put_header(REQ_DATA, SEQ_W'(2 * PAYLOAD_BYTES + 1), FULL_LEN);
    put_header(REQ_SYN, SEQ_W'(4 * PAYLOAD_BYTES + 1), FULL_LEN);
    put_header(REQ_BAD, SEQ_W'($urandom()), LEN_W'($urandom_range(0, PAYLOAD_BYTES)));
    // empty final segment caps the ack and releases the window
    put_header(REQ_DATA, SEQ_W'(SPAN + 1), '0);
    // final marker outside the window whose end wraps to zero
    put_header(REQ_DATA, SEQ_TOP, LEN_W'(1));
    grid = SEQ_W'(SPAN + 1);

    // Random windows: mostly full ones, some closed early by a short segment
    while (hdr_count < HEADERS) begin
      if (hdr_count >= QUIET_AFTER) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap_pct   = idle_mix[$urandom_range(0, 3)];
        stall_pct = idle_mix[$urandom_range(0, 3)];
      end
      closing   = ($urandom_range(0, 7) == 0);
      top_slot  = closing ? $urandom_range(0, SLOTS - 1) : SLOTS - 1;
      short_len = LEN_W'($urandom_range(0, PAYLOAD_BYTES - 2));
      need      = SLOTS'((1 << (top_slot + 1)) - 1);
      filled    = '0;
      while ((filled & need) != need) begin
        if ($urandom_range(0, 99) < 25) begin
          send_noise();
        end else begin
          k = $urandom_range(0, top_slot);
          put_header(data_req(), SEQ_W'(grid + 1 + PAYLOAD_BYTES * k),
                     (closing && k == top_slot) ? short_len : FULL_LEN);
          filled[k] = 1'b1;
        end
      end
      if (closing) begin
        // window now starts at the capped ack; wrap the final marker back to unknown
        grid     = SEQ_W'(grid + 1 + PAYLOAD_BYTES * top_slot + short_len);
        tail_len = LEN_W'($urandom_range(1, PAYLOAD_BYTES - 1));
        put_header(data_req(), SEQ_W'(32'h8000_0000 - tail_len), tail_len);
      end else begin
        grid = SEQ_W'(grid + SPAN);
      end
    end

    // Close the session, then headers once done
    put_header(REQ_FIN, SEQ_W'($urandom()), LEN_W'($urandom_range(0, PAYLOAD_BYTES)));
    repeat (4) begin
      put_header(any_req(1'b1), SEQ_W'($urandom()),
                 LEN_W'($urandom_range(0, PAYLOAD_BYTES)));
    end
    req_valid <= 1'b0;

    // Drain outstanding acks, then allow for the pipeline
    for (w = 0; w < 4000 && due_count != 0; w++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("** sliding_window_receive_tracker_unit: PASSED **");
    end else begin
      if (due_count != 0) $display("%0d expected acks never arrived", due_count);
      $display("** sliding_window_receive_tracker_unit: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("** sliding_window_receive_tracker_unit: FAILED **");
    $finish;
  end

endmodule
